/* hw/rtl/rspm_pkg.sv */
// Shared constants, codes and types of the rotate and scale pixel mapper.
package rspm_pkg;

    localparam int SOURCE_WORDS = 65536;
    localparam int PLAY_MAX     = 1024;

    localparam int SRC_AW    = $clog2(SOURCE_WORDS);
    localparam int PEN_DEPTH = 256;
    localparam int PEN_AW    = $clog2(PEN_DEPTH);

    localparam int SW_W     = 9;
    localparam int SH_W     = 9;
    localparam int PLAY_W   = 11;
    localparam int ORG_W    = 10;
    localparam int STRIDE_W = 11;
    localparam int COORD_W  = 10;
    localparam int INDEX_W  = 16;
    localparam int COLOR_W  = 8;
    localparam int PIX_W    = 8;
    localparam int DEST_W   = 21;
    localparam int SADDR_W  = 16;
    localparam int KIND_W   = 2;

    localparam int NUM_W  = COORD_W + SW_W;
    localparam int Q_W    = SW_W;
    localparam int DEN_W  = PLAY_W;
    localparam int DIV_W  = DEN_W + Q_W - 1;
    localparam int FULL_W = 2 * SW_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    localparam logic [KIND_W-1:0] KIND_PEN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SRC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REQ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_STRIDE = 3'd6;

    typedef struct packed {
        logic [SW_W-1:0]     sw;
        logic [SH_W-1:0]     sh;
        logic [PLAY_W-1:0]   pw;
        logic [PLAY_W-1:0]   ph;
        logic [ORG_W-1:0]    ox;
        logic [ORG_W-1:0]    oy;
        logic [STRIDE_W-1:0] stride;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] index;
        logic [PIX_W-1:0]   pen;
        logic [PIX_W-1:0]   src_pixel;
        logic               in_play;
        logic [DEST_W-1:0]  dest;
    } item_t;

    typedef struct packed {
        logic               in_play;
        logic [SADDR_W-1:0] saddr;
        logic [DEST_W-1:0]  dest;
        logic [PIX_W-1:0]   pixel;
    } res_t;

endpackage

/* hw/rtl/rspm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module rspm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/rspm_front.sv */
// Input register, coordinate products, range check and destination address stages.
module rspm_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [rspm_pkg::KIND_W-1:0]         in_kind,
    input  logic [rspm_pkg::INDEX_W-1:0]        in_index,
    input  logic [rspm_pkg::COLOR_W-1:0]        in_red,
    input  logic [rspm_pkg::COLOR_W-1:0]        in_green,
    input  logic [rspm_pkg::COLOR_W-1:0]        in_blue,
    input  logic [rspm_pkg::PIX_W-1:0]          in_src_pixel,
    input  logic [rspm_pkg::COORD_W-1:0]        in_x,
    input  logic [rspm_pkg::COORD_W-1:0]        in_y,
    input  rspm_pkg::cfg_t                      cfg,
    output logic                                c_valid,
    output rspm_pkg::item_t                     c_item,
    output logic [rspm_pkg::NUM_W-1:0]          c_ny,
    output logic [rspm_pkg::NUM_W-1:0]          c_nx
);

    logic                              a_valid_reg;
    logic [rspm_pkg::KIND_W-1:0]       a_kind_reg;
    logic [rspm_pkg::INDEX_W-1:0]      a_index_reg;
    logic [rspm_pkg::PIX_W-1:0]        a_pen_reg;
    logic [rspm_pkg::PIX_W-1:0]        a_pix_reg;
    logic [rspm_pkg::COORD_W-1:0]      a_x_reg;
    logic [rspm_pkg::COORD_W-1:0]      a_y_reg;

    logic                              b_valid_reg;
    rspm_pkg::item_t                   b_item_reg;
    rspm_pkg::item_t                   b_item_next;
    logic [rspm_pkg::PLAY_W-1:0]       b_xo_reg;
    logic [rspm_pkg::NUM_W-1:0]        b_ny_reg;
    logic [rspm_pkg::NUM_W-1:0]        b_nx_reg;
    logic [rspm_pkg::PLAY_W-1:0]       ysum;

    logic                              c_valid_reg;
    rspm_pkg::item_t                   c_item_reg;
    rspm_pkg::item_t                   c_item_next;
    logic [rspm_pkg::NUM_W-1:0]        c_ny_reg;
    logic [rspm_pkg::NUM_W-1:0]        c_nx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_comb begin
        ysum = rspm_pkg::PLAY_W'(cfg.oy) + rspm_pkg::PLAY_W'(a_y_reg);
        b_item_next.kind      = a_kind_reg;
        b_item_next.index     = a_index_reg;
        b_item_next.pen       = a_pen_reg;
        b_item_next.src_pixel = a_pix_reg;
        b_item_next.in_play   = (rspm_pkg::PLAY_W'(a_x_reg) < cfg.pw)
                             && (rspm_pkg::PLAY_W'(a_y_reg) < cfg.ph);
        b_item_next.dest      = rspm_pkg::DEST_W'(ysum) * rspm_pkg::DEST_W'(cfg.stride);

        c_item_next      = b_item_reg;
        c_item_next.dest = b_item_reg.dest + rspm_pkg::DEST_W'(b_xo_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_kind_reg  <= in_kind;
            a_index_reg <= in_index;
            a_pen_reg   <= {in_red[7:5], in_green[7:5], in_blue[7:6]};
            a_pix_reg   <= in_src_pixel;
            a_x_reg     <= in_x;
            a_y_reg     <= in_y;

            b_item_reg  <= b_item_next;
            b_xo_reg    <= rspm_pkg::PLAY_W'(cfg.ox) + rspm_pkg::PLAY_W'(a_x_reg);
            b_ny_reg    <= rspm_pkg::NUM_W'(a_y_reg) * rspm_pkg::NUM_W'(cfg.sw);
            b_nx_reg    <= rspm_pkg::NUM_W'(a_x_reg) * rspm_pkg::NUM_W'(cfg.sh);

            c_item_reg  <= c_item_next;
            c_ny_reg    <= b_ny_reg;
            c_nx_reg    <= b_nx_reg;
        end
    end

    assign c_valid = c_valid_reg;
    assign c_item  = c_item_reg;
    assign c_ny    = c_ny_reg;
    assign c_nx    = c_nx_reg;

endmodule

/* hw/rtl/rspm_div.sv */
// Pipelined restoring divider that settles one quotient bit per stage.
module rspm_div (
    input  logic                        aclk,
    input  logic                        adv,
    input  logic [rspm_pkg::NUM_W-1:0]  num,
    input  logic [rspm_pkg::DEN_W-1:0]  den,
    output logic [rspm_pkg::Q_W-1:0]    quo
);

    logic [rspm_pkg::DIV_W-1:0] rem_in   [rspm_pkg::Q_W];
    logic [rspm_pkg::Q_W-1:0]   quo_in   [rspm_pkg::Q_W];
    logic [rspm_pkg::DIV_W-1:0] rem_reg  [rspm_pkg::Q_W];
    logic [rspm_pkg::Q_W-1:0]   quo_reg  [rspm_pkg::Q_W];
    logic [rspm_pkg::DIV_W-1:0] rem_next [rspm_pkg::Q_W];
    logic [rspm_pkg::Q_W-1:0]   quo_next [rspm_pkg::Q_W];

    assign rem_in[0] = rspm_pkg::DIV_W'(num);
    assign quo_in[0] = '0;

    for (genvar j = 1; j < rspm_pkg::Q_W; j++) begin : g_link
        assign rem_in[j] = rem_reg[j-1];
        assign quo_in[j] = quo_reg[j-1];
    end

    always_comb begin
        logic [rspm_pkg::DIV_W-1:0] dsh;
        for (int j = 0; j < rspm_pkg::Q_W; j++) begin
            dsh = rspm_pkg::DIV_W'(den) << (rspm_pkg::Q_W - 1 - j);
            if (rem_in[j] >= dsh) begin
                rem_next[j] = rem_in[j] - dsh;
                quo_next[j] = quo_in[j]
                            | (rspm_pkg::Q_W'(1) << (rspm_pkg::Q_W - 1 - j));
            end else begin
                rem_next[j] = rem_in[j];
                quo_next[j] = quo_in[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < rspm_pkg::Q_W; j++) begin
                rem_reg[j] <= rem_next[j];
                quo_reg[j] <= quo_next[j];
            end
        end
    end

    assign quo = quo_reg[rspm_pkg::Q_W-1];

endmodule

/* hw/rtl/rspm_addr.sv */
// Source column and row, row offset product and source address stages.
module rspm_addr (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  rspm_pkg::item_t               in_item,
    input  logic [rspm_pkg::Q_W-1:0]      qy,
    input  logic [rspm_pkg::Q_W-1:0]      qx,
    input  rspm_pkg::cfg_t                cfg,
    output logic                          g_valid,
    output rspm_pkg::item_t               g_item,
    output logic                          g_hit,
    output logic [rspm_pkg::SADDR_W-1:0]  g_saddr
);

    logic                               e_valid_reg;
    rspm_pkg::item_t                    e_item_reg;
    logic [rspm_pkg::SW_W-1:0]          e_col_reg;
    logic [rspm_pkg::Q_W-1:0]           e_row_reg;
    logic [rspm_pkg::SW_W-1:0]          col_next;

    logic                               f_valid_reg;
    rspm_pkg::item_t                    f_item_reg;
    logic [rspm_pkg::SW_W-1:0]          f_col_reg;
    logic [2*rspm_pkg::SW_W-1:0]        f_prod_reg;

    logic                               g_valid_reg;
    rspm_pkg::item_t                    g_item_reg;
    logic                               g_hit_reg;
    logic [rspm_pkg::SADDR_W-1:0]       g_saddr_reg;
    logic [rspm_pkg::FULL_W-1:0]        full;

    always_comb begin
        if (cfg.sw == '0) begin
            col_next = '0;
        end else begin
            col_next = cfg.sw - rspm_pkg::SW_W'(1) - rspm_pkg::SW_W'(qy);
        end
        full = rspm_pkg::FULL_W'(f_prod_reg) + rspm_pkg::FULL_W'(f_col_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end else if (adv) begin
            e_valid_reg <= in_valid;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_item_reg  <= in_item;
            e_col_reg   <= col_next;
            e_row_reg   <= qx;
            f_item_reg  <= e_item_reg;
            f_col_reg   <= e_col_reg;
            f_prod_reg  <= (2*rspm_pkg::SW_W)'(e_row_reg) * (2*rspm_pkg::SW_W)'(cfg.sw);
            g_item_reg  <= f_item_reg;
            g_hit_reg   <= 32'(full) < rspm_pkg::SOURCE_WORDS;
            g_saddr_reg <= full[rspm_pkg::SADDR_W-1:0];
        end
    end

    assign g_valid = g_valid_reg;
    assign g_item  = g_item_reg;
    assign g_hit   = g_hit_reg;
    assign g_saddr = g_saddr_reg;

endmodule

/* hw/rtl/rotate_scale_pixel_mapper.sv */
// Top level of the rotate-by-270, nearest-neighbor scaling pixel mapper.
// Input beats arrive on s_tvalid/s_tready; s_tuser selects the operation: a pen write
// stores an RGB332 color, a source write stores one byte of the native frame, and a pixel
// request returns one result beat on m_tvalid/m_tready carrying the pen value, the
// destination address, the source address read and the in-range flag.
// Writes return nothing. Geometry registers are loaded through cfg_valid/cfg_index/cfg_data,
// which is always ready, and must only be written while no beat is in flight.
// A request passes the input register, two front stages, nine divider stages (one quotient
// bit each), three address stages, the source frame read, the pen read and the output
// register. One beat is accepted every cycle while the skid register is empty.
// Writes take effect at the stage where the same store is read, so every request sees
// exactly the writes accepted before it.
// After reset every pen reads as zero through a per-entry valid flag; the source frame
// comes up undefined and needs no clearing pass, so beats are accepted right away.
// When the receiver stalls, the result waits in the output register and one more result
// lands in a skid register; only then does the pipeline freeze and s_tready drop.
module rotate_scale_pixel_mapper (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // index[15:0], red[23:16], green[31:24], blue[39:32], src_pixel[47:40],
    // out_x[57:48], out_y[67:58], zero[71:68]
    input  logic [rspm_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type[1:0]
    input  logic [rspm_pkg::KIND_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel[7:0], dest_address[28:8], src_address[44:29], zero[47:45]
    output logic [rspm_pkg::M_TDATA_W-1:0]      m_tdata,
    // in_range[0]
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rspm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rspm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [rspm_pkg::SW_W-1:0]      sw_reg;
    logic [rspm_pkg::SH_W-1:0]      sh_reg;
    logic [rspm_pkg::PLAY_W-1:0]    pw_reg;
    logic [rspm_pkg::PLAY_W-1:0]    ph_reg;
    logic [rspm_pkg::ORG_W-1:0]     ox_reg;
    logic [rspm_pkg::ORG_W-1:0]     oy_reg;
    logic [rspm_pkg::STRIDE_W-1:0]  stride_reg;
    rspm_pkg::cfg_t                 cfg;

    logic                           adv;

    logic                           c_valid;
    rspm_pkg::item_t                c_item;
    logic [rspm_pkg::NUM_W-1:0]     c_ny;
    logic [rspm_pkg::NUM_W-1:0]     c_nx;
    logic [rspm_pkg::Q_W-1:0]       qy;
    logic [rspm_pkg::Q_W-1:0]       qx;

    logic                           dl_valid_reg [rspm_pkg::Q_W];
    rspm_pkg::item_t                dl_item_reg  [rspm_pkg::Q_W];

    logic                           g_valid;
    rspm_pkg::item_t                g_item;
    logic                           g_hit;
    logic [rspm_pkg::SADDR_W-1:0]   g_saddr;

    logic                           src_we;
    logic [rspm_pkg::PIX_W-1:0]     src_rdata;
    logic                           h_valid_reg;
    rspm_pkg::item_t                h_item_reg;
    logic                           h_hit_reg;
    logic [rspm_pkg::SADDR_W-1:0]   h_saddr_reg;
    logic [rspm_pkg::PIX_W-1:0]     h_byte;

    logic                           pen_we;
    logic [rspm_pkg::PIX_W-1:0]     pen_rdata;
    logic [rspm_pkg::PEN_DEPTH-1:0] pen_set_reg;
    logic                           i_valid_reg;
    rspm_pkg::item_t                i_item_reg;
    logic [rspm_pkg::SADDR_W-1:0]   i_saddr_reg;
    logic                           i_pen_ok_reg;

    rspm_pkg::res_t                 res;
    logic                           res_push;
    logic                           m_valid_reg;
    rspm_pkg::res_t                 m_res_reg;
    logic                           skid_valid_reg;
    rspm_pkg::res_t                 skid_res_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg     <= rspm_pkg::SW_W'(256);
            sh_reg     <= rspm_pkg::SH_W'(224);
            pw_reg     <= rspm_pkg::PLAY_W'(425);
            ph_reg     <= rspm_pkg::PLAY_W'(486);
            ox_reg     <= rspm_pkg::ORG_W'(219);
            oy_reg     <= '0;
            stride_reg <= rspm_pkg::STRIDE_W'(864);
        end else if (cfg_valid) begin
            case (cfg_index)
                rspm_pkg::CFG_SRC_WIDTH:   sw_reg     <= cfg_data[rspm_pkg::SW_W-1:0];
                rspm_pkg::CFG_SRC_HEIGHT:  sh_reg     <= cfg_data[rspm_pkg::SH_W-1:0];
                rspm_pkg::CFG_PLAY_WIDTH:  pw_reg     <= cfg_data[rspm_pkg::PLAY_W-1:0];
                rspm_pkg::CFG_PLAY_HEIGHT: ph_reg     <= cfg_data[rspm_pkg::PLAY_W-1:0];
                rspm_pkg::CFG_ORIGIN_X:    ox_reg     <= cfg_data[rspm_pkg::ORG_W-1:0];
                rspm_pkg::CFG_ORIGIN_Y:    oy_reg     <= cfg_data[rspm_pkg::ORG_W-1:0];
                rspm_pkg::CFG_DEST_STRIDE: stride_reg <= cfg_data[rspm_pkg::STRIDE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // The play rectangle saturates at its largest supported size.
    always_comb begin
        cfg.sw     = sw_reg;
        cfg.sh     = sh_reg;
        cfg.ox     = ox_reg;
        cfg.oy     = oy_reg;
        cfg.stride = stride_reg;
        cfg.pw     = (32'(pw_reg) > rspm_pkg::PLAY_MAX)
                   ? rspm_pkg::PLAY_W'(rspm_pkg::PLAY_MAX) : pw_reg;
        cfg.ph     = (32'(ph_reg) > rspm_pkg::PLAY_MAX)
                   ? rspm_pkg::PLAY_W'(rspm_pkg::PLAY_MAX) : ph_reg;
    end

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    rspm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (s_tvalid),
        .in_kind      (s_tuser),
        .in_index     (s_tdata[15:0]),
        .in_red       (s_tdata[23:16]),
        .in_green     (s_tdata[31:24]),
        .in_blue      (s_tdata[39:32]),
        .in_src_pixel (s_tdata[47:40]),
        .in_x         (s_tdata[57:48]),
        .in_y         (s_tdata[67:58]),
        .cfg          (cfg),
        .c_valid      (c_valid),
        .c_item       (c_item),
        .c_ny         (c_ny),
        .c_nx         (c_nx)
    );

    rspm_div u_div_col (
        .aclk (aclk),
        .adv  (adv),
        .num  (c_ny),
        .den  (cfg.ph),
        .quo  (qy)
    );

    rspm_div u_div_row (
        .aclk (aclk),
        .adv  (adv),
        .num  (c_nx),
        .den  (cfg.pw),
        .quo  (qx)
    );

    // Beat information travels beside the divider stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < rspm_pkg::Q_W; j++) begin
                dl_valid_reg[j] <= 1'b0;
            end
        end else if (adv) begin
            dl_valid_reg[0] <= c_valid;
            for (int j = 1; j < rspm_pkg::Q_W; j++) begin
                dl_valid_reg[j] <= dl_valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dl_item_reg[0] <= c_item;
            for (int j = 1; j < rspm_pkg::Q_W; j++) begin
                dl_item_reg[j] <= dl_item_reg[j-1];
            end
        end
    end

    rspm_addr u_addr (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (dl_valid_reg[rspm_pkg::Q_W-1]),
        .in_item  (dl_item_reg[rspm_pkg::Q_W-1]),
        .qy       (qy),
        .qx       (qx),
        .cfg      (cfg),
        .g_valid  (g_valid),
        .g_item   (g_item),
        .g_hit    (g_hit),
        .g_saddr  (g_saddr)
    );

    // Source frame read and write.
    assign src_we = adv && g_valid && (g_item.kind == rspm_pkg::KIND_SRC)
                 && (32'(g_item.index) < rspm_pkg::SOURCE_WORDS);

    rspm_ram #(
        .WIDTH (rspm_pkg::PIX_W),
        .DEPTH (rspm_pkg::SOURCE_WORDS)
    ) u_src_ram (
        .aclk  (aclk),
        .we    (src_we),
        .waddr (g_item.index[rspm_pkg::SRC_AW-1:0]),
        .wdata (g_item.src_pixel),
        .re    (adv),
        .raddr (g_saddr[rspm_pkg::SRC_AW-1:0]),
        .rdata (src_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
        end else if (adv) begin
            h_valid_reg <= g_valid;
            i_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            h_item_reg   <= g_item;
            h_hit_reg    <= g_hit;
            h_saddr_reg  <= g_saddr;
            i_item_reg   <= h_item_reg;
            i_saddr_reg  <= h_saddr_reg;
            i_pen_ok_reg <= pen_set_reg[h_byte];
        end
    end

    // Pen table read and write.
    assign h_byte = h_hit_reg ? src_rdata : '0;
    assign pen_we = adv && h_valid_reg && (h_item_reg.kind == rspm_pkg::KIND_PEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_set_reg <= '0;
        end else if (pen_we) begin
            pen_set_reg[h_item_reg.index[rspm_pkg::PEN_AW-1:0]] <= 1'b1;
        end
    end

    rspm_ram #(
        .WIDTH (rspm_pkg::PIX_W),
        .DEPTH (rspm_pkg::PEN_DEPTH)
    ) u_pen_ram (
        .aclk  (aclk),
        .we    (pen_we),
        .waddr (h_item_reg.index[rspm_pkg::PEN_AW-1:0]),
        .wdata (h_item_reg.pen),
        .re    (adv),
        .raddr (h_byte),
        .rdata (pen_rdata)
    );

    always_comb begin
        res.in_play = i_item_reg.in_play;
        res.dest    = i_item_reg.dest;
        res.saddr   = i_item_reg.in_play ? i_saddr_reg : '0;
        res.pixel   = (i_item_reg.in_play && i_pen_ok_reg) ? pen_rdata : '0;
    end

    assign res_push = adv && i_valid_reg && (i_item_reg.kind == rspm_pkg::KIND_REQ);

    // Output register with a one-beat skid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= res_push;
            end
        end else if (res_push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_res_reg <= skid_res_reg;
            end else if (res_push) begin
                m_res_reg <= res;
            end
        end else if (res_push) begin
            skid_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_res_reg.saddr, m_res_reg.dest, m_res_reg.pixel};
    assign m_tuser  = m_res_reg.in_play;

    a_skid_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds a beat while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("skid register filled without a receiver stall");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_res_reg.in_play) |->
            (m_res_reg.pixel == '0) && (m_res_reg.saddr == '0))
        else $error("out-of-range result carries a pixel or a source address");

endmodule

/* test/rotate_scale_pixel_mapper_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the rotate and scale pixel mapper with a pixel scoreboard.
module rotate_scale_pixel_mapper_tb;

    localparam logic [rspm_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;

    typedef struct packed {
        logic [rspm_pkg::KIND_W-1:0]  kind;
        logic [rspm_pkg::INDEX_W-1:0] index;
        logic [rspm_pkg::COLOR_W-1:0] red;
        logic [rspm_pkg::COLOR_W-1:0] green;
        logic [rspm_pkg::COLOR_W-1:0] blue;
        logic [rspm_pkg::PIX_W-1:0]   src_pixel;
        logic [rspm_pkg::COORD_W-1:0] out_x;
        logic [rspm_pkg::COORD_W-1:0] out_y;
    } beat_t;

    class pixel_mapper_scoreboard;
        logic [rspm_pkg::PIX_W-1:0] pens [rspm_pkg::PEN_DEPTH];
        logic [rspm_pkg::PIX_W-1:0] frame [rspm_pkg::SOURCE_WORDS];
        bit                         written [rspm_pkg::SOURCE_WORDS];
        int unsigned                src_w, src_h, play_w, play_h, org_x, org_y, stride;
        rspm_pkg::res_t             pending_pixels [$];
        int                         mismatches;

        function new();
            foreach (pens[i]) pens[i] = '0;
            src_w      = 256;
            src_h      = 224;
            play_w     = 425;
            play_h     = 486;
            org_x      = 219;
            org_y      = 0;
            stride     = 864;
            mismatches = 0;
        endfunction

        function void set_register(logic [rspm_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
            case (idx)
                rspm_pkg::CFG_SRC_WIDTH:   src_w  = value % (1 << rspm_pkg::SW_W);
                rspm_pkg::CFG_SRC_HEIGHT:  src_h  = value % (1 << rspm_pkg::SH_W);
                rspm_pkg::CFG_PLAY_WIDTH:  play_w = value % (1 << rspm_pkg::PLAY_W);
                rspm_pkg::CFG_PLAY_HEIGHT: play_h = value % (1 << rspm_pkg::PLAY_W);
                rspm_pkg::CFG_ORIGIN_X:    org_x  = value % (1 << rspm_pkg::ORG_W);
                rspm_pkg::CFG_ORIGIN_Y:    org_y  = value % (1 << rspm_pkg::ORG_W);
                rspm_pkg::CFG_DEST_STRIDE: stride = value % (1 << rspm_pkg::STRIDE_W);
                default: ;
            endcase
        endfunction

        function void map_coordinate(int unsigned x, int unsigned y,
                                     output bit in_play, output int unsigned full);
            int unsigned pw_eff, ph_eff, col, row;
            pw_eff  = play_w > rspm_pkg::PLAY_MAX ? rspm_pkg::PLAY_MAX : play_w;
            ph_eff  = play_h > rspm_pkg::PLAY_MAX ? rspm_pkg::PLAY_MAX : play_h;
            in_play = (x < pw_eff) && (y < ph_eff);
            full    = 0;
            if (in_play) begin
                col = 0;
                if (src_w != 0) col = (src_w - 1) - (y * src_w) / ph_eff;
                row  = (x * src_h) / pw_eff;
                full = row * src_w + col;
            end
        endfunction

        function void accept_beat(beat_t b);
            rspm_pkg::res_t             want;
            bit                         in_play;
            int unsigned                full, dest;
            logic [rspm_pkg::PIX_W-1:0] src_byte;
            case (b.kind)
                rspm_pkg::KIND_PEN: begin
                    pens[b.index[rspm_pkg::PEN_AW-1:0]] =
                        {b.red[7:5], b.green[7:5], b.blue[7:6]};
                end
                rspm_pkg::KIND_SRC: begin
                    if (int'(b.index) < rspm_pkg::SOURCE_WORDS) begin
                        frame[b.index]   = b.src_pixel;
                        written[b.index] = 1'b1;
                    end
                end
                rspm_pkg::KIND_REQ: begin
                    map_coordinate(32'(b.out_x), 32'(b.out_y), in_play, full);
                    dest     = (org_y + 32'(b.out_y)) * stride + org_x + 32'(b.out_x);
                    src_byte = '0;
                    if (in_play && full < rspm_pkg::SOURCE_WORDS) src_byte = frame[full];
                    want.pixel   = in_play ? pens[src_byte] : '0;
                    want.dest    = dest[rspm_pkg::DEST_W-1:0];
                    want.saddr   = in_play ? full[rspm_pkg::SADDR_W-1:0] : '0;
                    want.in_play = in_play;
                    pending_pixels.push_back(want);
                end
                default: ;
            endcase
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
        endtask

        task check_pixel(logic [rspm_pkg::M_TDATA_W-1:0] data, logic in_range);
            rspm_pkg::res_t want;
            if (pending_pixels.size() == 0) begin
                report("unexpected result beat", data[31:0], 32'd0);
            end else begin
                want = pending_pixels.pop_front();
                if (data[7:0] !== want.pixel)
                    report("pixel", 32'(data[7:0]), 32'(want.pixel));
                if (data[28:8] !== want.dest)
                    report("dest_address", 32'(data[28:8]), 32'(want.dest));
                if (data[44:29] !== want.saddr)
                    report("src_address", 32'(data[44:29]), 32'(want.saddr));
                if (in_range !== want.in_play)
                    report("in_range", 32'(in_range), 32'(want.in_play));
            end
        endtask
    endclass

    bit                                aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [rspm_pkg::S_TDATA_W-1:0]    s_tdata;
    logic [rspm_pkg::KIND_W-1:0]       s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [rspm_pkg::M_TDATA_W-1:0]    m_tdata;
    logic                              m_tuser;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [rspm_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [rspm_pkg::CFG_DATA_W-1:0]   cfg_data;

    pixel_mapper_scoreboard sb;
    int unsigned            recent_reads [$];
    int                     idle_pct;
    bit                     long_hold_due;
    int                     cycle_count;
    int                     beats_sent;

    rotate_scale_pixel_mapper i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tuser);
    end

    initial begin : result_receiver
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (long_hold_due) begin
                long_hold_due = 1'b0;
                hold_left     = LONG_HOLD - 1;
                m_tready     <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                hold_left = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic beat_t random_beat(logic [rspm_pkg::KIND_W-1:0] kind);
        beat_t b;
        b.kind      = kind;
        b.index     = rspm_pkg::INDEX_W'($urandom_range(0, 16'hFFFF));
        b.red       = rspm_pkg::COLOR_W'($urandom_range(0, 255));
        b.green     = rspm_pkg::COLOR_W'($urandom_range(0, 255));
        b.blue      = rspm_pkg::COLOR_W'($urandom_range(0, 255));
        b.src_pixel = rspm_pkg::PIX_W'($urandom_range(0, 255));
        b.out_x     = rspm_pkg::COORD_W'($urandom_range(0, 1023));
        b.out_y     = rspm_pkg::COORD_W'($urandom_range(0, 1023));
        return b;
    endfunction

    function automatic int unsigned pick_coord(int unsigned extent);
        int unsigned span;
        span = extent > rspm_pkg::PLAY_MAX ? rspm_pkg::PLAY_MAX : extent;
        if (span == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
        if ($urandom_range(0, 9) == 0) return span - 1;
        return $urandom_range(0, span - 1);
    endfunction

    task automatic push_beat(beat_t b);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, b.out_y, b.out_x, b.src_pixel, b.blue, b.green, b.red, b.index};
        s_tuser  <= b.kind;
        do @(posedge aclk); while (!s_tready);
        sb.accept_beat(b);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_request(int unsigned x, int unsigned y);
        beat_t       b;
        bit          in_play;
        int unsigned full;
        sb.map_coordinate(x, y, in_play, full);
        if (in_play && full < rspm_pkg::SOURCE_WORDS) begin
            if (!sb.written[full]) begin
                b       = random_beat(rspm_pkg::KIND_SRC);
                b.index = full[rspm_pkg::INDEX_W-1:0];
                push_beat(b);
            end
            recent_reads.push_back(full);
            if (recent_reads.size() > 16) void'(recent_reads.pop_front());
        end
        b       = random_beat(rspm_pkg::KIND_REQ);
        b.out_x = x[rspm_pkg::COORD_W-1:0];
        b.out_y = y[rspm_pkg::COORD_W-1:0];
        push_beat(b);
    endtask

    task automatic run_random(int count);
        beat_t       b;
        int          stop, pick;
        int unsigned addr;
        stop = beats_sent + count;
        while (beats_sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                b = random_beat(rspm_pkg::KIND_PEN);
                if (recent_reads.size() != 0 && $urandom_range(0, 1) == 1) begin
                    addr          = recent_reads[$urandom_range(0, recent_reads.size() - 1)];
                    b.index[7:0]  = sb.frame[addr];
                end
                push_beat(b);
            end else if (pick < 30) begin
                b = random_beat(rspm_pkg::KIND_SRC);
                if (recent_reads.size() != 0 && $urandom_range(0, 2) != 0) begin
                    addr    = recent_reads[$urandom_range(0, recent_reads.size() - 1)];
                    b.index = addr[rspm_pkg::INDEX_W-1:0];
                end
                push_beat(b);
            end else if (pick < 34) begin
                push_beat(random_beat(KIND_NONE));
            end else begin
                send_request(pick_coord(sb.play_w), pick_coord(sb.play_h));
            end
        end
    endtask

    task automatic write_register(logic [rspm_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[rspm_pkg::CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, value);
        @(negedge aclk);
    endtask

    task automatic write_geometry(int unsigned sw, int unsigned sh, int unsigned pw,
                                  int unsigned ph, int unsigned ox, int unsigned oy,
                                  int unsigned stride);
        s_tvalid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_register(rspm_pkg::CFG_SRC_WIDTH, sw);
        write_register(rspm_pkg::CFG_SRC_HEIGHT, sh);
        write_register(rspm_pkg::CFG_PLAY_WIDTH, pw);
        write_register(rspm_pkg::CFG_PLAY_HEIGHT, ph);
        write_register(rspm_pkg::CFG_ORIGIN_X, ox);
        write_register(rspm_pkg::CFG_ORIGIN_Y, oy);
        write_register(rspm_pkg::CFG_DEST_STRIDE, stride);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        beat_t b;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        idle_pct      = 0;
        long_hold_due = 1'b0;
        cycle_count   = 0;
        beats_sent    = 0;
        sb            = new();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        b = random_beat(rspm_pkg::KIND_PEN);
        b.index = 16'h0000; b.red = 8'hFF; b.green = 8'hFF; b.blue = 8'hFF;
        push_beat(b);
        b = random_beat(rspm_pkg::KIND_PEN);
        b.index = 16'hFFFF; b.red = 8'h00; b.green = 8'hFF; b.blue = 8'h00;
        push_beat(b);
        b = random_beat(rspm_pkg::KIND_PEN);
        b.index = 16'hFF01; b.red = 8'hFF; b.green = 8'h00; b.blue = 8'h00;
        push_beat(b);
        b = random_beat(rspm_pkg::KIND_PEN);
        b.index = 16'h00AA; b.red = 8'h5A; b.green = 8'hA5; b.blue = 8'h3C;
        push_beat(b);
        b = random_beat(rspm_pkg::KIND_SRC);
        b.index = 16'h0000; b.src_pixel = 8'hFF;
        push_beat(b);
        b = random_beat(rspm_pkg::KIND_SRC);
        b.index = 16'hFFFF; b.src_pixel = 8'h01;
        push_beat(b);
        send_request(0, 0);
        send_request(424, 485);
        send_request(212, 243);
        send_request(425, 0);
        send_request(0, 486);
        send_request(1023, 1023);
        send_request(0, 485);
        send_request(424, 0);
        b = '1;
        push_beat(b);
        b = random_beat(rspm_pkg::KIND_SRC);
        b.index = 16'd255; b.src_pixel = 8'hAA;
        push_beat(b);
        send_request(0, 0);

        idle_pct = 15;
        run_random(60);

        idle_pct = 25;
        write_geometry(16, 12, 40, 30, 5, 3, 64);
        long_hold_due = 1'b1;
        run_random(60);

        idle_pct = 10;
        write_geometry(1, 1, 1, 1, 0, 0, 1);
        run_random(20);

        write_geometry(0, 0, 0, 0, 0, 0, 0);
        run_random(15);

        idle_pct = 0;
        write_geometry(0, 37, 100, 90, 10, 20, 200);
        run_random(30);

        idle_pct = 20;
        write_geometry(256, 256, 1024, 1024, 1023, 1023, 1024);
        run_random(50);

        write_geometry(511, 511, 2047, 2047, 1023, 1023, 2047);
        run_random(40);

        write_geometry(511, 511, 100, 100, 0, 0, 2047);
        run_random(25);

        for (int i = 0; i < 3; i++) begin
            idle_pct = $urandom_range(0, 2) * 12;
            if (i != 2) begin
                write_geometry($urandom_range(1, 256), $urandom_range(1, 256),
                               $urandom_range(1, 1024), $urandom_range(1, 1024),
                               $urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(1, 1024));
            end else begin
                write_geometry($urandom_range(0, 511), $urandom_range(0, 511),
                               $urandom_range(0, 2047), $urandom_range(0, 2047),
                               $urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 2047));
            end
            run_random(35);
        end

        idle_pct = 0;
        write_geometry(24, 20, 48, 60, 100, 7, 320);
        run_random(60);

        s_tvalid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
